FILE: rtl/opcode_target_predictor_macros.svh
// assertion macros for the opcode target predictor checker
`ifndef OPCODE_TARGET_PREDICTOR_MACROS_SVH
`define OPCODE_TARGET_PREDICTOR_MACROS_SVH

// implication checked in the cycle after the antecedent
`define OPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// delayed implication: the consequent is checked after the antecedent
`define OPT_ASSERT_AFTER2(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

// implication checked in the same cycle
`define OPT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/opt_pkg.sv
// shared types, constants and outcome codes of the opcode target predictor
`timescale 1ns / 1ps

package opt_pkg;

    localparam int OPCODE_COUNT_DEF = 256;
    localparam int COUNT_BITS_DEF   = 32;

    localparam logic [3:0] USAGE_CEIL = 4'd8;
    localparam logic [3:0] USAGE_INIT = 4'd4;
    localparam logic [1:0] CONF_CEIL  = 2'd3;
    localparam logic [1:0] CONF_INIT  = 2'd3;

    localparam logic [2:0] OUTC_PREDICT        = 3'd0;
    localparam logic [2:0] OUTC_IGNORED        = 3'd1;
    localparam logic [2:0] OUTC_LEARNED        = 3'd2;
    localparam logic [2:0] OUTC_CORRECT        = 3'd3;
    localparam logic [2:0] OUTC_WRONG_KEPT     = 3'd4;
    localparam logic [2:0] OUTC_WRONG_REPLACED = 3'd5;

    localparam logic ACT_PREDICT = 1'b0;
    localparam logic ACT_UPDATE  = 1'b1;

    typedef struct packed {
        logic               action;
        logic [7:0]         opcode;
        logic signed [63:0] correct_target;
    } opt_req_t;

    typedef struct packed {
        logic signed [63:0] predicted_target;
        logic [2:0]         outcome;
        logic               entry_valid;
        logic [31:0]        hit_count;
        logic [31:0]        miss_count;
    } opt_rsp_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic exec;
    } opt_cmd_t;

    typedef struct packed {
        logic clear_last;
    } opt_sts_t;

endpackage

FILE: rtl/opt_ctrl.sv
// controller state machine: clearing pass, idle, execute
`timescale 1ns / 1ps

module opt_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  opt_pkg::opt_sts_t sts,
    output opt_pkg::opt_cmd_t cmd,
    output logic              busy
);
    import opt_pkg::*;

    typedef enum logic [2:0]
    {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

FILE: rtl/opt_dpath.sv
// datapath: entry store, read of one entry, update and result register
`timescale 1ns / 1ps

module opt_dpath
#(
    parameter int OPCODE_COUNT = opt_pkg::OPCODE_COUNT_DEF,
    parameter int COUNT_BITS   = opt_pkg::COUNT_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  opt_pkg::opt_cmd_t cmd,
    input  opt_pkg::opt_req_t request,
    output opt_pkg::opt_sts_t sts,
    output logic              done,
    output opt_pkg::opt_rsp_t result
);
    import opt_pkg::*;

    localparam int IDX_W = $clog2(OPCODE_COUNT);
    localparam int TAB_N = 256;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic signed [63:0]    tgt_mem  [OPCODE_COUNT];
    logic                  val_mem  [OPCODE_COUNT];
    logic [3:0]            use_mem  [OPCODE_COUNT];
    logic [1:0]            conf_mem [OPCODE_COUNT];
    logic [COUNT_BITS-1:0] hit_mem  [OPCODE_COUNT];
    logic [COUNT_BITS-1:0] miss_mem [OPCODE_COUNT];

    logic [IDX_W-1:0] idx_tab [TAB_N];
    logic [IDX_W-1:0] idx;

    logic [IDX_W-1:0]      clr_addr_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  act_reg;
    logic signed [63:0]    ct_reg;
    logic signed [63:0]    rd_tgt_reg;
    logic                  rd_val_reg;
    logic [3:0]            rd_use_reg;
    logic [1:0]            rd_conf_reg;
    logic [COUNT_BITS-1:0] rd_hit_reg;
    logic [COUNT_BITS-1:0] rd_miss_reg;
    logic                  done_reg;
    opt_rsp_t              result_reg;

    logic signed [63:0]    tgt_next;
    logic                  val_next;
    logic [3:0]            use_next;
    logic [1:0]            conf_next;
    logic [COUNT_BITS-1:0] hit_next;
    logic [COUNT_BITS-1:0] miss_next;
    opt_rsp_t              result_next;

    // opcode to entry index, folded into the table
    for (genvar g = 0; g < TAB_N; g++)
    begin : g_idx
        assign idx_tab[g] = IDX_W'(g % OPCODE_COUNT);
    end

    assign idx = idx_tab[request.opcode];
    assign sts.clear_last = (clr_addr_reg == IDX_W'(OPCODE_COUNT - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_addr_reg <= clr_addr_reg + IDX_W'(1);
            end
            done_reg <= cmd.exec;
        end
    end

    // entry store: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            tgt_mem[clr_addr_reg]  <= '0;
            val_mem[clr_addr_reg]  <= 1'b1;
            use_mem[clr_addr_reg]  <= USAGE_INIT;
            conf_mem[clr_addr_reg] <= CONF_INIT;
            hit_mem[clr_addr_reg]  <= '0;
            miss_mem[clr_addr_reg] <= '0;
        end
        else if (cmd.exec)
        begin
            tgt_mem[idx_reg]  <= tgt_next;
            val_mem[idx_reg]  <= val_next;
            use_mem[idx_reg]  <= use_next;
            conf_mem[idx_reg] <= conf_next;
            hit_mem[idx_reg]  <= hit_next;
            miss_mem[idx_reg] <= miss_next;
        end
        if (cmd.load)
        begin
            idx_reg     <= idx;
            act_reg     <= request.action;
            ct_reg      <= request.correct_target;
            rd_tgt_reg  <= tgt_mem[idx];
            rd_val_reg  <= val_mem[idx];
            rd_use_reg  <= use_mem[idx];
            rd_conf_reg <= conf_mem[idx];
            rd_hit_reg  <= hit_mem[idx];
            rd_miss_reg <= miss_mem[idx];
        end
        if (cmd.exec)
        begin
            result_reg <= result_next;
        end
    end

    always_comb
    begin
        tgt_next    = rd_tgt_reg;
        val_next    = rd_val_reg;
        use_next    = rd_use_reg;
        conf_next   = rd_conf_reg;
        hit_next    = rd_hit_reg;
        miss_next   = rd_miss_reg;
        result_next = '0;
        result_next.outcome = OUTC_PREDICT;
        result_next.predicted_target = rd_val_reg ? rd_tgt_reg : 64'sd0;

        if (act_reg == ACT_UPDATE)
        begin
            if (!rd_val_reg)
            begin
                result_next.outcome = OUTC_IGNORED;
            end
            else if (rd_tgt_reg == 64'sd0)
            begin
                tgt_next            = ct_reg;
                result_next.outcome = OUTC_LEARNED;
            end
            else if (rd_tgt_reg == ct_reg)
            begin
                if (rd_conf_reg < CONF_CEIL)
                begin
                    conf_next = rd_conf_reg + 2'd1;
                end
                if (rd_use_reg < USAGE_CEIL)
                begin
                    use_next = rd_use_reg + 4'd1;
                end
                if (rd_hit_reg != COUNT_MAX)
                begin
                    hit_next = rd_hit_reg + COUNT_BITS'(1);
                end
                result_next.outcome = OUTC_CORRECT;
            end
            else
            begin
                if (rd_conf_reg > 2'd1)
                begin
                    conf_next           = rd_conf_reg - 2'd1;
                    result_next.outcome = OUTC_WRONG_KEPT;
                end
                else
                begin
                    conf_next           = CONF_INIT;
                    tgt_next            = ct_reg;
                    result_next.outcome = OUTC_WRONG_REPLACED;
                end
                if (rd_use_reg > 4'd0)
                begin
                    use_next = rd_use_reg - 4'd1;
                end
                else
                begin
                    val_next = 1'b0;
                end
                if (rd_miss_reg != COUNT_MAX)
                begin
                    miss_next = rd_miss_reg + COUNT_BITS'(1);
                end
            end
        end

        result_next.entry_valid = val_next;
        result_next.hit_count   = 32'(hit_next);
        result_next.miss_count  = 32'(miss_next);
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: rtl/opcode_target_predictor.sv
// top level of the opcode target predictor
//
//  channel   direction  handshake          payload
//  request   in         start && !busy     opt_req_t
//  result    out        done (one cycle)   opt_rsp_t
//
//  an accepted item is read from the entry store into registers at acceptance; in the
//  following cycle the execute state updates the entry through its single write port and
//  registers the result, which is shown with done; no new item is accepted before that
//  after reset busy stays high while every entry of the store is cleared
//  done is not held off: the result is taken in the cycle it appears
`timescale 1ns / 1ps

module opcode_target_predictor
#(
    parameter int OPCODE_COUNT = opt_pkg::OPCODE_COUNT_DEF,
    parameter int COUNT_BITS   = opt_pkg::COUNT_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  opt_pkg::opt_req_t request,
    output logic              done,
    output opt_pkg::opt_rsp_t result
);
    import opt_pkg::*;

    opt_cmd_t cmd;
    opt_sts_t sts;

    opt_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    opt_dpath
    #(
        .OPCODE_COUNT (OPCODE_COUNT),
        .COUNT_BITS   (COUNT_BITS)
    )
    u_dpath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .sts     (sts),
        .done    (done),
        .result  (result)
    );

endmodule

FILE: rtl/opt_checker.sv
// port-level checker for the opcode target predictor and its bind
`timescale 1ns / 1ps
`include "opcode_target_predictor_macros.svh"

module opt_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input opt_pkg::opt_req_t request,
    input logic              done,
    input opt_pkg::opt_rsp_t result
);
    import opt_pkg::*;

    `OPT_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "not busy after accept")
    `OPT_ASSERT_AFTER2(a_result_latency, start && !busy, done, "result missing")
    `OPT_ASSERT_NEXT(a_single_strobe, done, !done, "result strobe repeated")
    `OPT_ASSERT_NOW(a_ignored_invalid, done && result.outcome == OUTC_IGNORED, !result.entry_valid, "ignored update on valid entry")
    `OPT_ASSERT_NOW(a_invalid_predict_zero, done && result.outcome == OUTC_PREDICT && !result.entry_valid, result.predicted_target == 64'sd0, "invalid entry predicts nonzero")

endmodule

bind opcode_target_predictor opt_checker u_opt_checker
(
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
);
